### src/mfi_pkg.sv
`default_nettype none
package mfi_pkg;

    localparam int NEURON_BITS = 6;
    localparam int LAYER_BITS  = 2;
    localparam int VALUE_BITS  = 16;
    localparam int WIDTH_BITS  = 7;
    localparam int MAX_NEURONS = 64;
    localparam int MAX_LAYERS  = 4;

    localparam logic [1:0] ACTION_WEIGHT = 2'd0;
    localparam logic [1:0] ACTION_BIAS   = 2'd1;
    localparam logic [1:0] ACTION_SAMPLE = 2'd2;

    localparam logic [1:0] KIND_SIGMOID  = 2'd0;
    localparam logic [1:0] KIND_SOFTMAX  = 2'd1;
    localparam logic [1:0] KIND_SOFTSIGN = 2'd2;

    localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] REG_INPUT_WIDTH = 3'd1;
    localparam logic [2:0] REG_WIDTH_ONE   = 3'd2;
    localparam logic [2:0] REG_WIDTH_TWO   = 3'd3;
    localparam logic [2:0] REG_WIDTH_THREE = 3'd4;
    localparam logic [2:0] REG_WIDTH_FOUR  = 3'd5;
    localparam logic [2:0] REG_ACT_KINDS   = 3'd6;

    typedef struct packed {
        logic [1:0]                   action;
        logic [LAYER_BITS-1:0]        layer;
        logic [NEURON_BITS-1:0]       row;
        logic [NEURON_BITS-1:0]       column;
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } req_t;

    typedef struct packed {
        logic [NEURON_BITS-1:0]       neuron_index;
        logic signed [VALUE_BITS-1:0] activation_value;
        logic                         final_res;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAC_ISSUE,
        S_MAC_DRAIN,
        S_BIAS,
        S_SMX_RD,
        S_SMX_EXP1,
        S_SMX_EXP2,
        S_SMX_SUM,
        S_ACT_RD,
        S_ACT_EXP1,
        S_ACT_EXP2,
        S_ACT_DIV_LD,
        S_ACT_DIV,
        S_ACT_WR,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic                   load_en;
        logic                   mac_issue;
        logic                   acc_clr;
        logic                   from_in;
        logic [LAYER_BITS-1:0]  layer;
        logic [NEURON_BITS-1:0] row;
        logic [NEURON_BITS-1:0] col;
        logic                   rd_bank;
        logic                   wr_bank;
        logic                   z_write;
        logic                   first;
        logic                   exp_first;
        logic                   exp_second;
        logic                   exp_from_max;
        logic                   sum_clr;
        logic                   sum_add;
        logic                   div_load;
        logic [1:0]             kind;
        logic                   lb_write;
        logic                   out_load;
        logic                   out_final;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } status_t;

    // e^-a in Q16, a = 0..11
    function automatic logic [16:0] exp_int(input logic [3:0] a);
        logic [16:0] r;
        case (a)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // e^-(j/16) in Q16, j = 0..16
    function automatic logic [16:0] exp_frac(input logic [4:0] j);
        logic [16:0] r;
        case (j)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd61565;
            5'd2:    r = 17'd57835;
            5'd3:    r = 17'd54331;
            5'd4:    r = 17'd51039;
            5'd5:    r = 17'd47947;
            5'd6:    r = 17'd45042;
            5'd7:    r = 17'd42313;
            5'd8:    r = 17'd39750;
            5'd9:    r = 17'd37341;
            5'd10:   r = 17'd35079;
            5'd11:   r = 17'd32954;
            5'd12:   r = 17'd30957;
            5'd13:   r = 17'd29081;
            5'd14:   r = 17'd27319;
            5'd15:   r = 17'd25664;
            5'd16:   r = 17'd24109;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [WIDTH_BITS-1:0] w);
        logic [WIDTH_BITS-1:0] r;
        if (w == '0)
            r = WIDTH_BITS'(1);
        else if (w > WIDTH_BITS'(MAX_NEURONS))
            r = WIDTH_BITS'(MAX_NEURONS);
        else
            r = w;
        return r;
    endfunction

endpackage
`default_nettype wire

### src/mfi_dp.sv
`default_nettype none
module mfi_dp
    import mfi_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  cmd_t    cmd,
    input  req_t    req,
    output status_t status,
    output rsp_t    rsp
);

    logic signed [VALUE_BITS-1:0] wmem [0:MAX_LAYERS*MAX_NEURONS*MAX_NEURONS-1];
    logic signed [VALUE_BITS-1:0] bmem [0:MAX_LAYERS*MAX_NEURONS-1];
    logic signed [VALUE_BITS-1:0] imem [0:MAX_NEURONS-1];
    logic signed [VALUE_BITS-1:0] lbmem [0:2*MAX_NEURONS-1];
    logic signed [VALUE_BITS-1:0] zmem [0:MAX_NEURONS-1];
    logic [16:0]                  emem [0:MAX_NEURONS-1];

    logic signed [VALUE_BITS-1:0] w_q, b_q, in_q, lb_q, z_q;
    logic [16:0]                  e_q;
    logic                         sel_in_q;

    logic                         v1_reg, v2_reg;
    logic signed [31:0]           prod_reg;
    logic signed [39:0]           acc_reg;
    logic signed [VALUE_BITS-1:0] max_reg;
    logic [16:0]                  ef_reg;
    logic [3:0]                   a_reg;
    logic                         a_zero_reg;
    logic [16:0]                  e_reg;
    logic [22:0]                  sum_reg;
    logic [22:0]                  den_reg;
    logic [22:0]                  rem_reg;
    logic [28:0]                  quo_reg;
    logic [4:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         neg_reg;
    rsp_t                         rsp_reg;

    logic signed [VALUE_BITS-1:0] x_val;
    logic signed [39:0]           biased;
    logic signed [39:0]           rounded;
    logic signed [VALUE_BITS-1:0] z_val;
    logic signed [16:0]           t_s;
    logic [16:0]                  t_u;
    logic [16:0]                  ef_lo, ef_hi;
    logic [19:0]                  interp;
    logic [33:0]                  e_prod;
    logic [15:0]                  mag;
    logic [28:0]                  num, dividend;
    logic [22:0]                  den;
    logic [23:0]                  trial;
    logic signed [VALUE_BITS-1:0] act_val;
    logic [6:0]                   lb_rd_addr;

    // weight, bias, sample stores
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && req.action == ACTION_WEIGHT)
            wmem[{req.layer, req.row, req.column}] <= req.value;
        w_q <= wmem[{cmd.layer, cmd.row, cmd.col}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_en && req.action == ACTION_BIAS)
            bmem[{req.layer, req.row}] <= req.value;
        b_q <= bmem[{cmd.layer, cmd.col}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_en && req.action == ACTION_SAMPLE)
            imem[req.row] <= req.value;
        in_q     <= imem[cmd.row];
        sel_in_q <= cmd.from_in;
    end

    assign lb_rd_addr = cmd.mac_issue ? {cmd.rd_bank, cmd.row} : {cmd.rd_bank, cmd.col};

    always_ff @(posedge clk)
    begin
        if (cmd.lb_write)
            lbmem[{cmd.wr_bank, cmd.col}] <= act_val;
        lb_q <= lbmem[lb_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.z_write)
            zmem[cmd.col] <= z_val;
        z_q <= zmem[cmd.col];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_add)
            emem[cmd.col] <= e_reg;
        e_q <= emem[cmd.col];
    end

    // MAC pipe: read, multiply, accumulate
    assign x_val = sel_in_q ? in_q : lb_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= x_val * w_q;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + 40'(prod_reg);
    end

    // bias, round half up, saturate
    assign biased  = acc_reg + (40'(b_q) <<< 12);
    assign rounded = (biased + 40'sd2048) >>> 12;
    always_comb
    begin
        if (rounded > 40'sd32767)
            z_val = 16'sh7fff;
        else if (rounded < -40'sd32768)
            z_val = -16'sh8000;
        else
            z_val = rounded[VALUE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.z_write && (cmd.first || z_val > max_reg))
            max_reg <= z_val;
    end

    // exp(-t): interpolate fraction, then scale by integer part
    always_comb
    begin
        if (cmd.exp_from_max)
            t_s = 17'(max_reg) - 17'(z_q);
        else if (z_q[VALUE_BITS-1])
            t_s = -17'(z_q);
        else
            t_s = 17'(z_q);
        t_u    = 17'(t_s);
        ef_lo  = exp_frac({1'b0, t_u[11:8]});
        ef_hi  = exp_frac(5'({1'b0, t_u[11:8]}) + 5'd1);
        interp = 20'(ef_lo - ef_hi) * 20'(t_u[7:0]);
    end

    assign e_prod = 34'(exp_int(a_reg)) * 34'(ef_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.exp_first)
        begin
            ef_reg     <= ef_lo - 17'((interp + 20'd128) >> 8);
            a_reg      <= t_u[15:12];
            a_zero_reg <= (t_u[16:12] >= 5'd12);
        end
        if (cmd.exp_second)
            e_reg <= a_zero_reg ? 17'd0 : 17'((e_prod + 34'd32768) >> 16);
        if (cmd.sum_clr)
            sum_reg <= '0;
        else if (cmd.sum_add)
            sum_reg <= sum_reg + 23'(e_reg);
    end

    // divider operands
    always_comb
    begin
        mag = z_q[VALUE_BITS-1] ? 16'(-z_q) : 16'(z_q);
        case (cmd.kind)
            KIND_SIGMOID:
            begin
                den = 23'd65536 + 23'(e_reg);
                num = z_q[VALUE_BITS-1] ? (29'(e_reg) << 12) : (29'd1 << 28);
            end
            KIND_SOFTMAX:
            begin
                den = sum_reg;
                num = 29'(e_q) << 12;
            end
            KIND_SOFTSIGN:
            begin
                den = 23'd4096 + 23'(mag);
                num = 29'(mag) << 12;
            end
            default:
            begin
                den = 23'd1;
                num = '0;
            end
        endcase
        dividend = num + 29'(den >> 1);
        trial    = {rem_reg, quo_reg[28]};
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd29;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 5'd1;
            busy_reg <= (cnt_reg != 5'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= den;
            neg_reg <= (cmd.kind == KIND_SOFTSIGN) && z_q[VALUE_BITS-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= 23'(trial - {1'b0, den_reg});
                quo_reg <= {quo_reg[27:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[22:0];
                quo_reg <= {quo_reg[27:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (cmd.kind != KIND_SIGMOID && cmd.kind != KIND_SOFTMAX && cmd.kind != KIND_SOFTSIGN)
            act_val = '0;
        else if (neg_reg)
            act_val = -$signed({3'b000, quo_reg[12:0]});
        else
            act_val = $signed({3'b000, quo_reg[12:0]});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.neuron_index     <= cmd.col;
            rsp_reg.activation_value <= lb_q;
            rsp_reg.final_res        <= cmd.out_final;
        end
    end

    assign rsp             = rsp_reg;
    assign status.div_busy = busy_reg;

    ap_no_reload: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !cmd.div_load)
        else $error("divider reloaded while busy");

    ap_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |=> busy_reg && cnt_reg == 5'd29)
        else $error("divider did not start");

    ap_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_issue |=> v1_reg ##1 v2_reg)
        else $error("mac pipe lost an issue");

endmodule
`default_nettype wire

### src/mfi_ctrl.sv
`default_nettype none
module mfi_ctrl
    import mfi_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        req_valid,
    input  req_t       req,
    output logic       req_stall,
    output logic       rsp_valid,
    input  wire        rsp_stall,
    input  wire        cfg_we,
    input  wire  [2:0] cfg_index,
    input  wire  [7:0] cfg_data,
    input  status_t    status,
    output cmd_t       cmd
);

    logic [2:0]            layer_count_reg;
    logic [WIDTH_BITS-1:0] input_width_reg, width_one_reg, width_two_reg;
    logic [WIDTH_BITS-1:0] width_three_reg, width_four_reg;
    logic [7:0]            act_kinds_reg;

    state_t                 state_reg, state_next;
    logic [LAYER_BITS-1:0]  layer_reg, layer_next;
    logic [NEURON_BITS-1:0] c_reg, c_next;
    logic [NEURON_BITS-1:0] r_reg, r_next;
    logic                   drain_reg, drain_next;
    logic                   out_valid_reg, out_valid_next;

    logic [2:0]            nl;
    logic [WIDTH_BITS-1:0] n_in, n_out;
    logic [1:0]            kind;
    logic                  last_r, last_c, last_layer, start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg <= 3'd3;
            input_width_reg <= 7'd38;
            width_one_reg   <= 7'd16;
            width_two_reg   <= 7'd8;
            width_three_reg <= 7'd1;
            width_four_reg  <= 7'd1;
            act_kinds_reg   <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LAYER_COUNT: layer_count_reg <= cfg_data[2:0];
                REG_INPUT_WIDTH: input_width_reg <= cfg_data[6:0];
                REG_WIDTH_ONE:   width_one_reg   <= cfg_data[6:0];
                REG_WIDTH_TWO:   width_two_reg   <= cfg_data[6:0];
                REG_WIDTH_THREE: width_three_reg <= cfg_data[6:0];
                REG_WIDTH_FOUR:  width_four_reg  <= cfg_data[6:0];
                REG_ACT_KINDS:   act_kinds_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (layer_count_reg == 3'd0)
            nl = 3'd1;
        else if (layer_count_reg > 3'(MAX_LAYERS))
            nl = 3'(MAX_LAYERS);
        else
            nl = layer_count_reg;
        case (layer_reg)
            2'd0:
            begin
                n_in  = clamp_width(input_width_reg);
                n_out = clamp_width(width_one_reg);
            end
            2'd1:
            begin
                n_in  = clamp_width(width_one_reg);
                n_out = clamp_width(width_two_reg);
            end
            2'd2:
            begin
                n_in  = clamp_width(width_two_reg);
                n_out = clamp_width(width_three_reg);
            end
            default:
            begin
                n_in  = clamp_width(width_three_reg);
                n_out = clamp_width(width_four_reg);
            end
        endcase
        kind       = act_kinds_reg[{layer_reg, 1'b0} +: 2];
        last_r     = (7'(r_reg) + 7'd1 == n_in);
        last_c     = (7'(c_reg) + 7'd1 == n_out);
        last_layer = (3'(layer_reg) + 3'd1 == nl);
        start      = (state_reg == S_IDLE) && req_valid
                     && req.action == ACTION_SAMPLE && req.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            layer_reg     <= '0;
            c_reg         <= '0;
            r_reg         <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            layer_reg     <= layer_next;
            c_reg         <= c_next;
            r_reg         <= r_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        layer_next     = layer_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;

        cmd              = '0;
        cmd.layer        = layer_reg;
        cmd.row          = r_reg;
        cmd.col          = c_reg;
        cmd.from_in      = (layer_reg == '0);
        cmd.rd_bank      = ~layer_reg[0];
        cmd.wr_bank      = layer_reg[0];
        cmd.kind         = kind;
        cmd.first        = (c_reg == '0);
        cmd.out_final    = last_c;
        req_stall        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.load_en = req_valid;
                if (start)
                begin
                    state_next = S_MAC_ISSUE;
                    layer_next = '0;
                    c_next     = '0;
                    r_next     = '0;
                end
            end
            S_MAC_ISSUE:
            begin
                cmd.mac_issue = 1'b1;
                cmd.acc_clr   = (r_reg == '0);
                if (last_r)
                begin
                    state_next = S_MAC_DRAIN;
                    drain_next = 1'b0;
                end
                else
                    r_next = r_reg + 6'd1;
            end
            S_MAC_DRAIN:
            begin
                if (drain_reg)
                    state_next = S_BIAS;
                else
                    drain_next = 1'b1;
            end
            S_BIAS:
            begin
                cmd.z_write = 1'b1;
                r_next      = '0;
                if (last_c)
                begin
                    c_next     = '0;
                    state_next = (kind == KIND_SOFTMAX) ? S_SMX_RD : S_ACT_RD;
                end
                else
                begin
                    c_next     = c_reg + 6'd1;
                    state_next = S_MAC_ISSUE;
                end
            end
            S_SMX_RD:
            begin
                cmd.sum_clr = (c_reg == '0);
                state_next  = S_SMX_EXP1;
            end
            S_SMX_EXP1:
            begin
                cmd.exp_first    = 1'b1;
                cmd.exp_from_max = 1'b1;
                state_next       = S_SMX_EXP2;
            end
            S_SMX_EXP2:
            begin
                cmd.exp_second = 1'b1;
                state_next     = S_SMX_SUM;
            end
            S_SMX_SUM:
            begin
                cmd.sum_add = 1'b1;
                if (last_c)
                begin
                    c_next     = '0;
                    state_next = S_ACT_RD;
                end
                else
                begin
                    c_next     = c_reg + 6'd1;
                    state_next = S_SMX_RD;
                end
            end
            S_ACT_RD:
            begin
                case (kind)
                    KIND_SIGMOID:  state_next = S_ACT_EXP1;
                    KIND_SOFTMAX:  state_next = S_ACT_DIV_LD;
                    KIND_SOFTSIGN: state_next = S_ACT_DIV_LD;
                    default:       state_next = S_ACT_WR;
                endcase
            end
            S_ACT_EXP1:
            begin
                cmd.exp_first = 1'b1;
                state_next    = S_ACT_EXP2;
            end
            S_ACT_EXP2:
            begin
                cmd.exp_second = 1'b1;
                state_next     = S_ACT_DIV_LD;
            end
            S_ACT_DIV_LD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_ACT_DIV;
            end
            S_ACT_DIV:
            begin
                if (!status.div_busy)
                    state_next = S_ACT_WR;
            end
            S_ACT_WR:
            begin
                cmd.lb_write = 1'b1;
                if (last_c)
                begin
                    c_next = '0;
                    r_next = '0;
                    if (last_layer)
                        state_next = S_OUT_RD;
                    else
                    begin
                        layer_next = layer_reg + 2'd1;
                        state_next = S_MAC_ISSUE;
                    end
                end
                else
                begin
                    c_next     = c_reg + 6'd1;
                    state_next = S_ACT_RD;
                end
            end
            S_OUT_RD:
            begin
                cmd.rd_bank = layer_reg[0];
                state_next  = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.rd_bank    = layer_reg[0];
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                cmd.rd_bank = layer_reg[0];
                if (!rsp_stall)
                begin
                    out_valid_next = 1'b0;
                    if (last_c)
                        state_next = S_IDLE;
                    else
                    begin
                        c_next     = c_reg + 6'd1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

    ap_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_OUT_WAIT)
        else $error("result shown outside output wait");

    ap_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg == S_MAC_ISSUE && r_reg == '0 && c_reg == '0 && layer_reg == '0)
        else $error("forward pass did not start clean");

    ap_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACT_DIV && !status.div_busy) |=> state_reg == S_ACT_WR)
        else $error("divider finish missed");

endmodule
`default_nettype wire

### src/mlp_forward_inference_unit.sv
// Pass: a last-marked sample starts the pass; per layer each neuron runs its MAC over n_in
//   inputs and its bias, then its activation (sigmoid, softmax, softsign or the zero code),
//   softmax first summing exponentials over the layer; results leave one at a time under rsp_stall.
// Flow: loads and non-last samples are accepted without stall while idle; the shared MAC and
//   bit-serial divider set the pass length. Inputs stall for the whole pass.
// Reset: asynchronous, active low; config returns to 3,38,16,8,1,1,0; stores are undefined.
`default_nettype none
module mlp_forward_inference_unit
    import mfi_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        req_valid,
    output logic       req_stall,
    input  req_t       req,
    output logic       rsp_valid,
    input  wire        rsp_stall,
    output rsp_t       rsp,
    input  wire        cfg_we,
    input  wire  [2:0] cfg_index,
    input  wire  [7:0] cfg_data
);

    // command and status between the sequencer and the datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: config registers, layer/neuron/row counters, handshakes
    mfi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: stores, MAC pipe, exp unit, divider, output register
    mfi_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .status (status),
        .rsp    (rsp)
    );

endmodule
`default_nettype wire

### tb/sv/mlp_forward_inference_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module mlp_forward_inference_unit_tb
    import mfi_pkg::*;
();

    // Clock and run limits. Networks here stay small; the limit covers the whole run
    // many times over under maximum stalls.
    localparam int  HALF_PERIOD = 6;
    localparam int  SETTLE      = 64;       // tail after the last result of a pass
    localparam longint LIMIT    = 2000000;

    // codes the block ignores or treats as the zero activation
    localparam logic [1:0] ACTION_NOP = 2'd3;
    localparam logic [1:0] KIND_ZERO  = 2'd3;
    localparam logic [2:0] REG_NONE   = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    mlp_forward_inference_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Our own copy of the exp tables: e^-a and e^-(j/16), both Q16.
    localparam longint EXP_WHOLE[12] = '{65536, 24109, 8869, 3263, 1200, 442,
                                         162, 60, 22, 8, 3, 1};
    localparam longint EXP_PART[17]  = '{65536, 61565, 57835, 54331, 51039, 47947,
                                         45042, 42313, 39750, 37341, 35079, 32954,
                                         30957, 29081, 27319, 25664, 24109};

    // Shadow of the configuration and the stores.
    logic [2:0] net_layers;
    logic [6:0] net_width[5];
    logic [7:0] net_kinds;
    logic signed [15:0] weight_mem[4][64][64];
    logic signed [15:0] bias_mem[4][64];
    logic signed [15:0] sample_mem[64];
    bit weight_set[4][64][64];
    bit bias_set[4][64];
    bit sample_set[64];

    rsp_t   neuron_q[$];   // expected output neurons, oldest first
    int     mismatches = 0;
    longint cycles = 0;
    bit     quiet = 1'b0;  // no idling on either side while set
    int     stall_left = 0;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stall after each accepted output item.
    always @(posedge clk)
    begin
        int hold;
        hold = stall_left;
        if (rsp_valid && !rsp_stall)
            hold = quiet ? 0 : $urandom_range(0, 6);
        else if (hold > 0)
            hold = hold - 1;
        stall_left <= hold;
        rsp_stall  <= (hold > 0);
    end

    // Output checker
    always @(posedge clk)
    begin
        rsp_t exp_n;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (neuron_q.size() == 0)
            begin
                $error("neuron_index: expected none, got %0d (unexpected item)",
                       rsp.neuron_index);
                mismatches++;
            end
            else
            begin
                exp_n = neuron_q.pop_front();
                if (rsp.neuron_index !== exp_n.neuron_index)
                begin
                    $error("neuron_index: expected %0d, got %0d",
                           exp_n.neuron_index, rsp.neuron_index);
                    mismatches++;
                end
                if (rsp.activation_value !== exp_n.activation_value)
                begin
                    $error("activation_value: expected %0d, got %0d",
                           exp_n.activation_value, rsp.activation_value);
                    mismatches++;
                end
                if (rsp.final_res !== exp_n.final_res)
                begin
                    $error("final_res: expected %0d, got %0d",
                           exp_n.final_res, rsp.final_res);
                    mismatches++;
                end
            end
        end
    end

    // ---------------- predictor ----------------

    function automatic int width_at(int k);
        int w;
        w = net_width[k];
        if (w == 0) return 1;
        return (w > MAX_NEURONS) ? MAX_NEURONS : w;
    endfunction

    function automatic int layers_used();
        int n;
        n = net_layers;
        if (n < 1) return 1;
        return (n > MAX_LAYERS) ? MAX_LAYERS : n;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint acc_add(longint acc, longint p);
        longint lim;
        lim = longint'(1) << 62;
        if (p > 0 && acc > lim - p) return lim;
        if (p < 0 && acc < -lim - p) return -lim;
        return acc + p;
    endfunction

    // round half up from Q8.24 to Q4.12
    function automatic longint q12_round(longint v);
        if (v >= 0) return (v + 2048) >>> 12;
        return -((-v + 2047) >>> 12);
    endfunction

    // e^-t for t >= 0 in Q.12, result Q0.16
    function automatic longint neg_exp(longint t);
        longint a, f, j, lo, ef;
        a = t >>> 12;
        if (a >= 12) return 0;
        f  = t & 4095;
        j  = f >>> 8;
        lo = f & 255;
        ef = EXP_PART[j] - (((EXP_PART[j] - EXP_PART[j+1]) * lo + 128) >>> 8);
        return (EXP_WHOLE[a] * ef + 32768) >>> 16;
    endfunction

    function automatic longint sigmoid_of(longint x);
        longint e, d, num;
        e   = neg_exp(x >= 0 ? x : -x);
        d   = 65536 + e;
        num = (x >= 0) ? (longint'(4096) << 16) : 4096 * e;
        return clip16((num + d / 2) / d);
    endfunction

    function automatic longint softsign_of(longint x);
        longint mag, d, q;
        mag = (x >= 0) ? x : -x;
        d   = 4096 + mag;
        q   = (mag * 4096 + d / 2) / d;
        return clip16(x >= 0 ? q : -q);
    endfunction

    // Full forward pass over the shadow stores; queues one item per output neuron.
    function automatic void forward_pass();
        longint vec[2][64];
        longint z[64];
        longint e[64];
        longint acc, m, sum, v;
        int nl, n_in, n_out, src, dst;
        logic [1:0] kind;
        rsp_t o;
        nl = layers_used();
        src = 0;
        for (int r = 0; r < 64; r++) vec[0][r] = sample_mem[r];
        n_out = width_at(0);
        for (int i = 0; i < nl; i++)
        begin
            dst   = src ^ 1;
            n_in  = width_at(i);
            n_out = width_at(i + 1);
            kind  = net_kinds[2*i +: 2];
            for (int c = 0; c < n_out; c++)
            begin
                acc = 0;
                for (int r = 0; r < n_in; r++)
                    acc = acc_add(acc, vec[src][r] * longint'(weight_mem[i][r][c]));
                acc  = acc_add(acc, longint'(bias_mem[i][c]) * 4096);
                z[c] = clip16(q12_round(acc));
            end
            if (kind == KIND_SOFTMAX)
            begin
                m = z[0];
                for (int c = 1; c < n_out; c++) if (z[c] > m) m = z[c];
                sum = 0;
                for (int c = 0; c < n_out; c++)
                begin
                    e[c] = neg_exp(m - z[c]);
                    sum += e[c];
                end
                for (int c = 0; c < n_out; c++)
                    vec[dst][c] = (sum == 0) ? 0 : clip16((e[c] * 4096 + sum / 2) / sum);
            end
            else
            begin
                for (int c = 0; c < n_out; c++)
                begin
                    v = 0;
                    if (kind == KIND_SIGMOID)       v = sigmoid_of(z[c]);
                    else if (kind == KIND_SOFTSIGN) v = softsign_of(z[c]);
                    vec[dst][c] = v;
                end
            end
            src = dst;
        end
        for (int c = 0; c < n_out; c++)
        begin
            o.neuron_index     = c[5:0];
            o.activation_value = vec[src][c][15:0];
            o.final_res        = (c + 1 == n_out);
            neuron_q = {neuron_q, o};
        end
    endfunction

    // Update shadow stores for an accepted item.
    function automatic void absorb_item(req_t r);
        case (r.action)
            ACTION_WEIGHT:
            begin
                weight_mem[r.layer][r.row][r.column] = r.value;
                weight_set[r.layer][r.row][r.column] = 1'b1;
            end
            ACTION_BIAS:
            begin
                bias_mem[r.layer][r.row] = r.value;
                bias_set[r.layer][r.row] = 1'b1;
            end
            ACTION_SAMPLE:
            begin
                sample_mem[r.row] = r.value;
                sample_set[r.row] = 1'b1;
                if (r.last) forward_pass();
            end
            default: ;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic req_t make_item(logic [1:0] act, logic [1:0] lyr, logic [5:0] row,
                                       logic [5:0] col, logic [15:0] val, logic lst);
        req_t r;
        r.action = act;
        r.layer  = lyr;
        r.row    = row;
        r.column = col;
        r.value  = val;
        r.last   = lst;
        return r;
    endfunction

    // Mostly moderate Q4.12 values, sometimes extremes or full range.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3:    return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // Sends one item; returns at the edge where it was accepted, valid still high.
    task automatic send_item(req_t r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        absorb_item(r);
    endtask

    // Drop valid, wait for every expected neuron, then let the block settle.
    task automatic drain();
        req_valid <= 1'b0;
        while (neuron_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_LAYER_COUNT: net_layers = val[2:0];
            REG_INPUT_WIDTH: net_width[0] = val[6:0];
            REG_WIDTH_ONE:   net_width[1] = val[6:0];
            REG_WIDTH_TWO:   net_width[2] = val[6:0];
            REG_WIDTH_THREE: net_width[3] = val[6:0];
            REG_WIDTH_FOUR:  net_width[4] = val[6:0];
            REG_ACT_KINDS:   net_kinds = val;
            default: ;
        endcase
    endtask

    task automatic set_network(logic [7:0] lc, logic [7:0] w0, logic [7:0] w1,
                               logic [7:0] w2, logic [7:0] w3, logic [7:0] w4,
                               logic [7:0] kinds);
        write_reg(REG_LAYER_COUNT, lc);
        write_reg(REG_INPUT_WIDTH, w0);
        write_reg(REG_WIDTH_ONE, w1);
        write_reg(REG_WIDTH_TWO, w2);
        write_reg(REG_WIDTH_THREE, w3);
        write_reg(REG_WIDTH_FOUR, w4);
        write_reg(REG_ACT_KINDS, kinds);
    endtask

    // Load every store entry the current network reads and that was never written,
    // so no pass ever touches an undefined entry.
    task automatic prime_network();
        int nl;
        nl = layers_used();
        for (int i = 0; i < nl; i++)
        begin
            for (int r = 0; r < width_at(i); r++)
                for (int c = 0; c < width_at(i + 1); c++)
                    if (!weight_set[i][r][c])
                        send_item(make_item(ACTION_WEIGHT, i[1:0], r[5:0], c[5:0],
                                            pick_value(), 1'b0));
            for (int c = 0; c < width_at(i + 1); c++)
                if (!bias_set[i][c])
                    send_item(make_item(ACTION_BIAS, i[1:0], c[5:0], 6'($urandom),
                                        pick_value(), 1'b0));
        end
        for (int r = 0; r < width_at(0); r++)
            if (!sample_set[r])
                send_item(make_item(ACTION_SAMPLE, 2'($urandom), r[5:0], 6'($urandom),
                                    pick_value(), 1'b0));
    endtask

    // A last-marked sample at a random in-range element.
    task automatic fire_pass(logic [15:0] val);
        send_item(make_item(ACTION_SAMPLE, 2'($urandom), 6'($urandom_range(0, width_at(0) - 1)),
                            6'($urandom), val, 1'b1));
    endtask

    // ---------------- tests ----------------

    // Reset layer count and activations: 3 sigmoid layers 2 -> 2 -> 2 -> 1.
    task automatic test_reset_network();
        write_reg(REG_INPUT_WIDTH, 8'd2);
        write_reg(REG_WIDTH_ONE, 8'd2);
        write_reg(REG_WIDTH_TWO, 8'd2);
        prime_network();
        fire_pass(pick_value());
        drain();
    endtask

    // Every activation kind, including the zero code, and extreme samples.
    task automatic test_activations();
        set_network(8'd4, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
                    {KIND_SOFTSIGN, KIND_SOFTMAX, KIND_SOFTMAX, KIND_SIGMOID});
        prime_network();
        fire_pass(16'h7fff);
        fire_pass(16'h8000);
        send_item(make_item(ACTION_SAMPLE, 2'd3, 6'd0, 6'd63, 16'h7fff, 1'b0));
        send_item(make_item(ACTION_SAMPLE, 2'd0, 6'd1, 6'd0, 16'h8000, 1'b0));
        fire_pass(16'h0000);
        drain();
        // zero code on the last layer: all outputs zero
        write_reg(REG_ACT_KINDS, {KIND_ZERO, KIND_SOFTSIGN, KIND_SOFTMAX, KIND_SIGMOID});
        fire_pass(16'h1000);
        drain();
        write_reg(REG_ACT_KINDS, {KIND_SIGMOID, KIND_SOFTSIGN, KIND_SOFTSIGN, KIND_SOFTSIGN});
        fire_pass(16'hf000);
        drain();
    endtask

    // Ignored items: action three, a last mark on loads, then store extremes.
    task automatic test_ignored_items();
        set_network(8'd1, 8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'h00);
        prime_network();
        send_item(make_item(ACTION_NOP, 2'd3, 6'd63, 6'd63, 16'hffff, 1'b1));
        send_item(make_item(ACTION_WEIGHT, 2'd3, 6'd63, 6'd63, 16'h8000, 1'b1));
        send_item(make_item(ACTION_BIAS, 2'd3, 6'd63, 6'd63, 16'h7fff, 1'b1));
        send_item(make_item(ACTION_WEIGHT, 2'd0, 6'd1, 6'd1, 16'h7fff, 1'b0));
        send_item(make_item(ACTION_BIAS, 2'd0, 6'd0, 6'd0, 16'h8000, 1'b0));
        fire_pass(16'h7fff);
        drain();
    endtask

    // Out-of-range register values clamp: layer count 0 and 7, input width 0.
    task automatic test_clamping();
        set_network(8'd0, 8'd0, 8'd3, 8'd1, 8'd1, 8'd1, {4{KIND_ZERO}});
        write_reg(REG_ACT_KINDS, {6'd0, KIND_SOFTSIGN});
        prime_network();
        fire_pass(pick_value());
        drain();
        set_network(8'd7, 8'd2, 8'd1, 8'd2, 8'd1, 8'd2, 8'h00);
        prime_network();
        fire_pass(pick_value());
        drain();
        write_reg(REG_NONE, 8'hAA);   // unknown index, no effect
        fire_pass(pick_value());
        drain();
    endtask

    // Back-to-back items and results: 3 -> 3 softmax, no idling on either side; then sigmoid.
    task automatic test_back_to_back();
        set_network(8'd1, 8'd3, 8'd3, 8'd1, 8'd1, 8'd1, {6'd0, KIND_SOFTMAX});
        quiet = 1'b1;
        prime_network();
        fire_pass(pick_value());
        fire_pass(pick_value());
        drain();
        quiet = 1'b0;
        write_reg(REG_ACT_KINDS, {6'd0, KIND_SIGMOID});
        fire_pass(pick_value());
        drain();
    endtask

    // Random networks; each phase mostly reloads weights and feeds samples,
    // with a pass every few items and some ignored noise.
    task automatic test_random_traffic();
        int sent;
        req_t r;
        sent = 0;
        while (sent < 30)
        begin
            set_network(8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)),
                        8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                        8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                        8'($urandom));
            quiet = ($urandom_range(0, 3) == 0);
            prime_network();
            for (int k = 0; k < 10; k++)
            begin
                case ($urandom_range(0, 11))
                    0, 1, 2:
                        r = make_item(ACTION_WEIGHT, 2'($urandom), 6'($urandom), 6'($urandom),
                                      pick_value(), 1'($urandom));
                    3:
                        r = make_item(ACTION_BIAS, 2'($urandom), 6'($urandom), 6'($urandom),
                                      pick_value(), 1'($urandom));
                    4, 5, 6, 7:
                        r = make_item(ACTION_SAMPLE, 2'($urandom), 6'($urandom), 6'($urandom),
                                      pick_value(), 1'b0);
                    8, 9, 10:
                        r = make_item(ACTION_SAMPLE, 2'($urandom), 6'($urandom), 6'($urandom),
                                      pick_value(), 1'b1);
                    default:
                        r = make_item(ACTION_NOP, 2'($urandom), 6'($urandom), 6'($urandom),
                                      16'($urandom), 1'($urandom));
                endcase
                send_item(r);
                if (r.action != ACTION_NOP) sent++;
            end
            drain();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        net_layers = 3'd3;
        net_width  = '{7'd38, 7'd16, 7'd8, 7'd1, 7'd1};
        net_kinds  = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_network();
        test_activations();
        test_ignored_items();
        test_clamping();
        test_back_to_back();
        test_random_traffic();

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
